// ===== hdl/obah_pkg.sv =====
// Shared types and constants for the one-at-a-time bucket hash.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package obah_pkg;

  localparam int HASH_W    = 64;
  localparam int BYTE_W    = 8;
  localparam int SIZE_W    = 32;
  localparam int STEP_W    = $clog2(HASH_W);
  localparam int FOLD_SHL  = 10;
  localparam int FOLD_SHR  = 6;
  localparam int MIX_SHL_A = 3;
  localparam int MIX_SHR   = 11;
  localparam int MIX_SHL_B = 15;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HASH_W - 1);

  localparam int ADDR_W = 3;
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(1);

  typedef logic [HASH_W-1:0] hash_t;

  typedef struct packed {
    logic  valid;
    hash_t hash;
  } obah_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } obah_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MIX_A,
    BK_MIX_B,
    BK_DIV,
    BK_OUT
  } obah_bk_state_t;

endpackage
`default_nettype wire

// ===== hdl/obah_front.sv =====
// Front end: accepts key bytes and folds them into the running hash.
// Pushes the folded hash of each finished key into the queue; uses obah_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obah_front
  import obah_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_key_byte,
  input  wire logic              in_byte_present,
  input  wire logic              in_key_last,
  input  wire obah_qstat_t       qstat,
  output obah_push_t             push
);

  hash_t hash_r;
  hash_t hash_nxt;
  hash_t byte_ext;
  hash_t summed;
  hash_t folded;
  logic  fire;

  assign in_ready = in_key_last ? !qstat.full : 1'b1;
  assign fire     = in_valid && in_ready;

  always_comb begin
    byte_ext = {{(HASH_W-BYTE_W){1'b0}}, in_key_byte};
    summed   = hash_r + (hash_r << FOLD_SHL) + byte_ext + (byte_ext << FOLD_SHL);
    folded   = in_byte_present ? (summed ^ (summed >> FOLD_SHR)) : hash_r;
  end

  always_comb begin
    hash_nxt = hash_r;
    if (fire) begin
      hash_nxt = in_key_last ? '0 : folded;
    end
  end

  assign push.valid = fire && in_key_last;
  assign push.hash  = folded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/obah_queue.sv =====
// Short queue of folded key hashes between front and back ends.
// Uses obah_pkg for the hash and status types.
`timescale 1ns / 1ps
`default_nettype none
module obah_queue
  import obah_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire obah_push_t push,
  input  wire logic       pop,
  output hash_t           head,
  output obah_qstat_t     qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hash_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count_r == CNT_FULL);
  assign qstat.empty = (count_r == '0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/obah_back.sv =====
// Back end: final mix of a queued hash and bit-serial reduction modulo table_size.
// Holds the bucket index in an output register; uses obah_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obah_back
  import obah_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hash_t             head,
  input  wire obah_qstat_t       qstat,
  output logic                   pop,
  input  wire logic [SIZE_W-1:0] table_size,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [SIZE_W-1:0]      out_bucket_index
);

  obah_bk_state_t    state_r, state_nxt;
  hash_t             h_r, h_nxt;
  hash_t             mix_a;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] div_r, div_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SIZE_W:0]   trial;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!qstat.empty) state_nxt = BK_MIX_A;
      BK_MIX_A: state_nxt = BK_MIX_B;
      BK_MIX_B: state_nxt = BK_DIV;
      BK_DIV:   if (step_r == LAST_STEP) state_nxt = BK_OUT;
      BK_OUT:   if (out_ready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: pop       = !qstat.empty;
      BK_OUT:  out_valid = 1'b1;
      default: begin
        pop       = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_bucket_index = rem_r;

  always_comb begin
    mix_a    = h_r + (h_r << MIX_SHL_A);
    trial    = {rem_r, h_r[HASH_W-1]};
    h_nxt    = h_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    case (state_r)
      BK_IDLE: begin
        h_nxt   = head;
        rem_nxt = '0;
        div_nxt = (table_size == '0) ? TABLE_SIZE_RESET : table_size;
      end
      BK_MIX_A: begin
        h_nxt = mix_a ^ (mix_a >> MIX_SHR);
      end
      BK_MIX_B: begin
        h_nxt    = h_r + (h_r << MIX_SHL_B);
        step_nxt = '0;
      end
      BK_DIV: begin
        h_nxt    = h_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = SIZE_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[SIZE_W-1:0];
        end
      end
      default: begin
        h_nxt = h_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/one_at_a_time_bucket_hash.sv =====
// One-at-a-time bucket hash, top level: front end, hash queue, back end, APB register.
// Depends on obah_pkg, obah_front, obah_queue and obah_back.
//
// Key bytes are taken one per cycle and folded into a 64-bit running hash in the
// front end; a byte that does not end a key never stalls. The item that ends a key
// passes its hash into a queue of QUEUE_DEPTH entries and clears the running hash.
// The back end takes one queued hash at a time: a pop in BK_IDLE, the final mix in
// BK_MIX_A and BK_MIX_B, then restoring remainder over all 64 hash bits in BK_DIV
// (one hash bit per cycle) against table_size, then the bucket index is held on
// out_bucket_index in BK_OUT until taken, and only then does the back end return to
// BK_IDLE to pop the next hash; the front end keeps folding the following key
// meanwhile and stalls only on a key end while the queue is full.
// table_size (byte address 0) reads back as written; zero reduces as one.
`timescale 1ns / 1ps
`default_nettype none
module one_at_a_time_bucket_hash
  import obah_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_key_byte,
  input  wire logic              in_byte_present,
  input  wire logic              in_key_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [SIZE_W-1:0]      out_bucket_index,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [SIZE_W-1:0] cfg_pwdata,
  output logic [SIZE_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [SIZE_W-1:0] table_size_r;
  logic [SIZE_W-1:0] table_size_nxt;
  logic              reg_sel;
  obah_push_t        push;
  obah_qstat_t       qstat;
  hash_t             head;
  logic              pop;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[ADDR_W-1] == REG_TABLE_SIZE);
  assign cfg_prdata = reg_sel ? table_size_r : '0;

  always_comb begin
    table_size_nxt = table_size_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      table_size_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RESET;
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  obah_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key_byte     (in_key_byte),
    .in_byte_present (in_byte_present),
    .in_key_last     (in_key_last),
    .qstat           (qstat),
    .push            (push)
  );

  obah_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  obah_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .qstat            (qstat),
    .pop              (pop),
    .table_size       (table_size_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bucket_index (out_bucket_index)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && qstat.full))
    else $error("hash pushed into a full queue");

  a_byte_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_key_last) |-> in_ready)
    else $error("non-final item stalled");

  a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((table_size_r == '0 && out_bucket_index == '0) ||
                   (out_bucket_index < table_size_r)))
    else $error("bucket index not below table size");

  a_pop_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!qstat.empty && !out_valid))
    else $error("queue popped while empty or result pending");

endmodule
`default_nettype wire
